// ===== rtl/jadm_pkg.sv =====
// ----------------------------------------------------------------------------
// jadm_pkg
// Shared types and constants for the joystick arcade drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package jadm_pkg;

  localparam int StickW   = 12;  // raw stick value
  localparam int ShapeW   = 10;  // shaped stick, signed, -510..255
  localparam int MixW     = 11;  // mixed motor speed, signed
  localparam int MagW     = MixW - 1;
  localparam int DzW      = 11;
  localparam int TimeW    = 16;
  localparam int KindW    = 8;
  localparam int DutyW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // shared divider
  localparam int DivNumW         = 20;
  localparam int DivDenW         = 11;
  localparam int DivBitsPerCycle = 2;

  localparam logic [KindW-1:0]  KindJoystick  = 8'h01;
  localparam logic [StickW-1:0] StickCentre   = 12'd2048;
  localparam logic [DzW-1:0]    StickTop      = 11'd2047;
  localparam int                FullSpeed     = 255;
  localparam logic [TimeW-1:0]  IdleMax       = 16'hFFFF;
  localparam logic [DzW-1:0]    DeadZoneReset = 11'd200;
  localparam logic [TimeW-1:0]  TimeoutReset  = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDeadZone = 1'b0,
    CfgTimeout  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ActPacket = 1'b0,
    ActTick   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StIssue,
    StWait,
    StMix,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    StepThrottle,
    StepSteer,
    StepLeft,
    StepRight
  } step_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/jadm_div.sv =====
// ----------------------------------------------------------------------------
// jadm_div
// Shared unsigned restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jadm_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire jadm_pkg::div_req_t req_i,
  output jadm_pkg::div_rsp_t      rsp_o
);

  localparam int NumW = jadm_pkg::DivNumW;
  localparam int DenW = jadm_pkg::DivDenW;
  localparam int Bpc  = jadm_pkg::DivBitsPerCycle;
  localparam int Iter = NumW / Bpc;
  localparam int CntW = (Iter > 1) ? $clog2(Iter) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;

  logic [DenW:0]   rem_t;
  logic [NumW-1:0] quo_t;

  // Bpc restoring steps per cycle; dividend shifts out as quotient shifts in
  always_comb begin
    rem_t = {1'b0, rem_q};
    quo_t = quo_q;
    for (int i = 0; i < Bpc; i++) begin
      rem_t = {rem_t[DenW-1:0], quo_t[NumW-1]};
      quo_t = {quo_t[NumW-2:0], 1'b0};
      if (rem_t >= {1'b0, den_q}) begin
        rem_t    = rem_t - {1'b0, den_q};
        quo_t[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = quo_t;
      rem_d = rem_t[DenW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Iter - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/joystick_arcade_drive_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_arcade_drive_mixer_unit
// Stores joystick packets, tracks the idle timer and produces one
// differential motor command per packet or millisecond tick.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    action, packet_kind, sticks
//  out      source     out_valid_o / out_ready_i  direction bits, duties, link, ack
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One item runs up to four divisions on the shared 2-bit-per-cycle divider,
//  plus update, mix and output steps. A timed-out item goes from the check
//  straight to output; no rescale skips the last two divisions.
//  in_ready_o is high only while the sequencer is idle; a result waiting in
//  the output register does not block the next transfer in, only its output.
//  Reset loads the register defaults and centred sticks; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_arcade_drive_mixer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [jadm_pkg::KindW-1:0]    packet_kind_i,
  input  wire logic [jadm_pkg::StickW-1:0]   throttle_raw_i,
  input  wire logic [jadm_pkg::StickW-1:0]   steer_raw_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               left_forward_o,
  output logic                               left_reverse_o,
  output logic [jadm_pkg::DutyW-1:0]         left_duty_o,
  output logic                               right_forward_o,
  output logic                               right_reverse_o,
  output logic [jadm_pkg::DutyW-1:0]         right_duty_o,
  output logic                               link_up_o,
  output logic                               ack_o,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [jadm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [jadm_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int StickW = jadm_pkg::StickW;
  localparam int ShapeW = jadm_pkg::ShapeW;
  localparam int MixW   = jadm_pkg::MixW;
  localparam int MagW   = jadm_pkg::MagW;
  localparam int DzW    = jadm_pkg::DzW;
  localparam int TimeW  = jadm_pkg::TimeW;
  localparam int DutyW  = jadm_pkg::DutyW;
  localparam int NumW   = jadm_pkg::DivNumW;
  localparam int DenW   = jadm_pkg::DivDenW;

  localparam logic signed [ShapeW-1:0] FullShape = ShapeW'(jadm_pkg::FullSpeed);
  localparam logic [MagW-1:0]          FullMag   = MagW'(jadm_pkg::FullSpeed);

  // x * 255 as a shift and subtract
  function automatic logic [NumW-1:0] mul_full(input logic [DzW-1:0] x);
    return NumW'({x, {DutyW{1'b0}}}) - NumW'(x);
  endfunction

  function automatic logic [MixW-1:0] mix_abs(input logic signed [MixW-1:0] v);
    return v[MixW-1] ? MixW'(-v) : MixW'(v);
  endfunction

  jadm_pkg::state_e state_q, state_d;
  jadm_pkg::step_e  step_q, step_d;

  logic [DzW-1:0]           dz_q;
  logic [TimeW-1:0]         timeout_q;
  logic [StickW-1:0]        thr_stick_q, thr_stick_d;
  logic [StickW-1:0]        str_stick_q, str_stick_d;
  logic [TimeW-1:0]         idle_q, idle_d;
  logic                     linked_q, linked_d;
  logic                     ack_q, ack_d;
  logic signed [ShapeW-1:0] shp_thr_q, shp_thr_d;
  logic signed [ShapeW-1:0] shp_str_q, shp_str_d;
  logic signed [MixW-1:0]   left_q, left_d;
  logic signed [MixW-1:0]   right_q, right_d;
  logic [MagW-1:0]          top_q, top_d;
  logic                     neg_q, neg_d;
  logic                     wrap_q, wrap_d;

  logic             out_valid_q, out_valid_d;
  logic             out_lf_q, out_lr_q, out_rf_q, out_rr_q, out_link_q, out_ack_q;
  logic [DutyW-1:0] out_ld_q, out_rd_q;

  jadm_pkg::div_req_t div_req;
  jadm_pkg::div_rsp_t div_rsp;

  logic in_fire, out_load;

  // stick shaping operands
  logic [StickW-1:0] stick;
  logic              stk_pos, stk_dead, stk_wrap, stk_skip;
  logic [StickW-1:0] stk_mag;
  logic [DzW-1:0]    stk_span, stk_base;

  // mixing operands
  logic signed [MixW-1:0] mix_left, mix_right;
  logic [MagW-1:0]        mix_la, mix_ra, mix_top;
  logic signed [MixW-1:0] mix_sel;
  logic [MagW-1:0]        mix_sel_mag;

  // divider results
  logic signed [ShapeW-1:0] q_shape, shape_post;
  logic signed [MixW-1:0]   q_mix, mix_post;

  jadm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == jadm_pkg::StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == jadm_pkg::StOut) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  // ---- shaping: c = stick - 2048, deadzone, linear scale ----
  always_comb begin
    stick    = (step_q == jadm_pkg::StepSteer) ? str_stick_q : thr_stick_q;
    stk_pos  = stick[StickW-1] && (|stick[StickW-2:0]);
    stk_mag  = stick[StickW-1] ? {1'b0, stick[StickW-2:0]} : (jadm_pkg::StickCentre - stick);
    stk_dead = (stick == jadm_pkg::StickCentre) || (stk_mag < StickW'(dz_q));
    stk_wrap = (stick == '0);
    stk_span = jadm_pkg::StickTop - dz_q;
    if (stk_pos) begin
      stk_base = stick[StickW-2:0] - dz_q;
    end else if (stk_wrap) begin
      stk_base = DzW'(1);  // lowest stick sits one step past the span
    end else begin
      stk_base = jadm_pkg::StickTop - stk_mag[DzW-1:0];
    end
    stk_skip = stk_dead || (stk_span == '0);
  end

  always_comb begin
    mix_left    = MixW'(shp_thr_q) + MixW'(shp_str_q);
    mix_right   = MixW'(shp_thr_q) - MixW'(shp_str_q);
    mix_la      = MagW'(mix_abs(mix_left));
    mix_ra      = MagW'(mix_abs(mix_right));
    mix_top     = (mix_la > mix_ra) ? mix_la : mix_ra;
    mix_sel     = (step_q == jadm_pkg::StepLeft) ? left_q : right_q;
    mix_sel_mag = MagW'(mix_abs(mix_sel));
  end

  always_comb begin
    q_shape = div_rsp.quotient[ShapeW-1:0];
    if (wrap_q) begin
      shape_post = -q_shape - FullShape;
    end else if (neg_q) begin
      shape_post = q_shape - FullShape;
    end else begin
      shape_post = q_shape;
    end
    q_mix    = div_rsp.quotient[MixW-1:0];
    mix_post = neg_q ? -q_mix : q_mix;
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jadm_pkg::StIdle: begin
        if (in_fire) state_d = jadm_pkg::StCheck;
      end
      jadm_pkg::StCheck: begin
        state_d = (idle_q > timeout_q) ? jadm_pkg::StOut : jadm_pkg::StIssue;
      end
      jadm_pkg::StIssue: begin
        if ((step_q == jadm_pkg::StepThrottle || step_q == jadm_pkg::StepSteer) && stk_skip) begin
          state_d = (step_q == jadm_pkg::StepSteer) ? jadm_pkg::StMix : jadm_pkg::StIssue;
        end else begin
          state_d = jadm_pkg::StWait;
        end
      end
      jadm_pkg::StWait: begin
        if (div_rsp.done) begin
          unique case (step_q)
            jadm_pkg::StepThrottle: state_d = jadm_pkg::StIssue;
            jadm_pkg::StepSteer:    state_d = jadm_pkg::StMix;
            jadm_pkg::StepLeft:     state_d = jadm_pkg::StIssue;
            jadm_pkg::StepRight:    state_d = jadm_pkg::StOut;
            default:                state_d = jadm_pkg::StIdle;
          endcase
        end
      end
      jadm_pkg::StMix: begin
        state_d = (mix_top > FullMag) ? jadm_pkg::StIssue : jadm_pkg::StOut;
      end
      jadm_pkg::StOut: begin
        if (out_load) state_d = jadm_pkg::StIdle;
      end
      default: state_d = jadm_pkg::StIdle;
    endcase
  end

  // ---- datapath control ----
  always_comb begin
    step_d      = step_q;
    thr_stick_d = thr_stick_q;
    str_stick_d = str_stick_q;
    idle_d      = idle_q;
    linked_d    = linked_q;
    ack_d       = ack_q;
    shp_thr_d   = shp_thr_q;
    shp_str_d   = shp_str_q;
    left_d      = left_q;
    right_d     = right_q;
    top_d       = top_q;
    neg_d       = neg_q;
    wrap_d      = wrap_q;
    div_req     = '0;

    unique case (state_q)
      jadm_pkg::StIdle: begin
        if (in_fire) begin
          ack_d = 1'b0;
          if (action_i == jadm_pkg::ActPacket) begin
            if (packet_kind_i == jadm_pkg::KindJoystick) begin
              thr_stick_d = throttle_raw_i;
              str_stick_d = steer_raw_i;
              idle_d      = '0;
              linked_d    = 1'b1;
              ack_d       = 1'b1;
            end
          end else if (idle_q != jadm_pkg::IdleMax) begin
            idle_d = idle_q + 1'b1;
          end
        end
      end
      jadm_pkg::StCheck: begin
        step_d = jadm_pkg::StepThrottle;
        if (idle_q > timeout_q) begin
          linked_d = 1'b0;
          left_d   = '0;
          right_d  = '0;
        end
      end
      jadm_pkg::StIssue: begin
        if (step_q == jadm_pkg::StepThrottle || step_q == jadm_pkg::StepSteer) begin
          if (stk_skip) begin
            // zero span on the negative side lands on full reverse
            if (step_q == jadm_pkg::StepThrottle) begin
              shp_thr_d = (stk_dead || stk_pos) ? '0 : -FullShape;
              step_d    = jadm_pkg::StepSteer;
            end else begin
              shp_str_d = (stk_dead || stk_pos) ? '0 : -FullShape;
            end
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_full(stk_base);
            div_req.divisor  = stk_span;
            neg_d            = !stk_pos;
            wrap_d           = stk_wrap;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_full(DzW'(mix_sel_mag));
          div_req.divisor  = DenW'(top_q);
          neg_d            = mix_sel[MixW-1];
          wrap_d           = 1'b0;
        end
      end
      jadm_pkg::StWait: begin
        if (div_rsp.done) begin
          unique case (step_q)
            jadm_pkg::StepThrottle: begin
              shp_thr_d = shape_post;
              step_d    = jadm_pkg::StepSteer;
            end
            jadm_pkg::StepSteer: shp_str_d = shape_post;
            jadm_pkg::StepLeft: begin
              left_d = mix_post;
              step_d = jadm_pkg::StepRight;
            end
            jadm_pkg::StepRight: right_d = mix_post;
            default: ;
          endcase
        end
      end
      jadm_pkg::StMix: begin
        left_d  = mix_left;
        right_d = mix_right;
        top_d   = mix_top;
        step_d  = jadm_pkg::StepLeft;
      end
      jadm_pkg::StOut: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jadm_pkg::StIdle;
      step_q      <= jadm_pkg::StepThrottle;
      dz_q        <= jadm_pkg::DeadZoneReset;
      timeout_q   <= jadm_pkg::TimeoutReset;
      thr_stick_q <= jadm_pkg::StickCentre;
      str_stick_q <= jadm_pkg::StickCentre;
      idle_q      <= '0;
      linked_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      thr_stick_q <= thr_stick_d;
      str_stick_q <= str_stick_d;
      idle_q      <= idle_d;
      linked_q    <= linked_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (jadm_pkg::cfg_idx_e'(cfg_index_i))
          jadm_pkg::CfgDeadZone: dz_q      <= cfg_data_i[DzW-1:0];
          jadm_pkg::CfgTimeout:  timeout_q <= cfg_data_i[TimeW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q     <= ack_d;
    shp_thr_q <= shp_thr_d;
    shp_str_q <= shp_str_d;
    left_q    <= left_d;
    right_q   <= right_d;
    top_q     <= top_d;
    neg_q     <= neg_d;
    wrap_q    <= wrap_d;
    if (out_load) begin
      out_lf_q   <= !left_q[MixW-1] && (|left_q);
      out_lr_q   <= left_q[MixW-1];
      out_ld_q   <= DutyW'(mix_abs(left_q));
      out_rf_q   <= !right_q[MixW-1] && (|right_q);
      out_rr_q   <= right_q[MixW-1];
      out_rd_q   <= DutyW'(mix_abs(right_q));
      out_link_q <= linked_q;
      out_ack_q  <= ack_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_forward_o  = out_lf_q;
  assign left_reverse_o  = out_lr_q;
  assign left_duty_o     = out_ld_q;
  assign right_forward_o = out_rf_q;
  assign right_reverse_o = out_rr_q;
  assign right_duty_o    = out_rd_q;
  assign link_up_o       = out_link_q;
  assign ack_o           = out_ack_q;

  // ---- assertions ----
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == jadm_pkg::StIssue) && !div_rsp.busy)
    else $error("divider started while busy or outside issue");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == jadm_pkg::StWait))
    else $error("divider finished with no one waiting");

  a_rescale_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == jadm_pkg::StIssue) &&
     (step_q == jadm_pkg::StepLeft || step_q == jadm_pkg::StepRight)) |-> (top_q > FullMag))
    else $error("mix rescale issued without overflow");

  a_packet_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == jadm_pkg::ActPacket && packet_kind_i == jadm_pkg::KindJoystick)
    |=> (idle_q == '0) && linked_q)
    else $error("joystick packet did not restart link");

endmodule

`default_nettype wire
